// ----- rtl/json_string_escape_encoder_defines.svh -----
// Assertion macros used by the JSON string escape encoder RTL.
`ifndef JSON_STRING_ESCAPE_ENCODER_DEFINES_SVH
`define JSON_STRING_ESCAPE_ENCODER_DEFINES_SVH
`ifndef ASSERT_OFF
`define JSE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define JSE_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define JSE_ASSERT(label, clk, rst_n, prop, msg)
`define JSE_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ----- rtl/jse_pkg.sv -----
// Types, character codes and helper functions for the JSON string escape encoder.
`default_nettype none
package jse_pkg;

    localparam int RunMax = 7;
    localparam int CountW = $clog2(RunMax + 1);

    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_U      = 8'h75;
    localparam logic [7:0] CHAR_B      = 8'h62;
    localparam logic [7:0] CHAR_F      = 8'h66;
    localparam logic [7:0] CHAR_N      = 8'h6E;
    localparam logic [7:0] CHAR_R      = 8'h72;
    localparam logic [7:0] CHAR_T      = 8'h74;
    localparam logic [7:0] CHAR_ERROR  = 8'h00;

    localparam logic [7:0] CTRL_BS  = 8'h08;
    localparam logic [7:0] CTRL_TAB = 8'h09;
    localparam logic [7:0] CTRL_LF  = 8'h0A;
    localparam logic [7:0] CTRL_FF  = 8'h0C;
    localparam logic [7:0] CTRL_CR  = 8'h0D;

    // no escape needed
    localparam logic [7:0] ESC_NONE = 8'h00;

    // top three bits of a UTF-8 lead byte
    localparam logic [2:0] LEAD_3BYTE = 3'b111;
    localparam logic [2:0] LEAD_2BYTE = 3'b110;

    typedef struct packed {
        logic [1:0]  need;
        logic [15:0] acc;
        logic        disc;
    } state_t;

    typedef struct packed {
        logic [RunMax-1:0][7:0] chars;
        logic [CountW-1:0]      count;
        logic                   str_end;
        logic                   bad;
    } run_t;

    function automatic logic [7:0] escape_char(input logic [7:0] b);
        logic [7:0] e;
        case (b)
            CHAR_QUOTE:  e = CHAR_QUOTE;
            CHAR_BSLASH: e = CHAR_BSLASH;
            CTRL_BS:     e = CHAR_B;
            CTRL_FF:     e = CHAR_F;
            CTRL_LF:     e = CHAR_N;
            CTRL_CR:     e = CHAR_R;
            CTRL_TAB:    e = CHAR_T;
            default:     e = ESC_NONE;
        endcase
        return e;
    endfunction

    // lowercase hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = 8'h30 + {4'h0, d};
        end
        else
        begin
            c = 8'h57 + {4'h0, d};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/json_string_escape_encoder.sv -----
// Top level of the JSON string escape encoder: state, run buffer and handshakes.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   in      | sink      | in_valid / in_stall  | in_byte, first_byte, last_byte
//   out     | source    | out_valid / out_stall| out_char, run_end, string_end, bad_char
//   cfg     | sink      | cfg_valid / cfg_ready| cfg_data (force_ucs2)
//
// An accepted byte is encoded in the cycle it arrives and its whole run of
// characters (zero to seven) lands in the run register; results leave one beat
// per cycle from there while out_stall is low. A byte yielding results holds the
// run register until its final beat leaves, so plain text streams at one byte
// per cycle while out_stall is low. The next byte is taken in the same cycle the
// final beat of the current run leaves. Reset clears the string state, the
// run count and force_ucs2; out_stall backs up into in_stall directly.
`default_nettype none
`include "json_string_escape_encoder_defines.svh"
module json_string_escape_encoder (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       first_byte,
    input  wire logic       last_byte,

    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_char,
    output logic            run_end,
    output logic            string_end,
    output logic            bad_char,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data
);

    logic                                 force_ucs2_reg;
    jse_pkg::state_t                      state_reg;
    jse_pkg::state_t                      state_next;
    jse_pkg::run_t                        enc_run;

    logic [jse_pkg::RunMax-1:0][7:0]      run_chars_reg;
    logic [jse_pkg::RunMax-1:0][7:0]      run_chars_next;
    logic [jse_pkg::CountW-1:0]           run_count_reg;
    logic [jse_pkg::CountW-1:0]           run_count_next;
    logic                                 run_end_flag_reg;
    logic                                 run_end_flag_next;
    logic                                 run_bad_reg;
    logic                                 run_bad_next;

    logic                                 in_fire;
    logic                                 out_fire;

    // The user must rewrite the register only while idle; the block does not enforce it, so always take it.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            force_ucs2_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            force_ucs2_reg <= cfg_data;
        end
    end

    // Encode the incoming byte against the current string state.
    jse_encode u_encode (
        .in_byte    (in_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .force_ucs2 (force_ucs2_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .run        (enc_run)
    );

    // Output side: head of the run register.
    assign out_valid  = (run_count_reg != '0);
    assign out_char   = run_chars_reg[0];
    assign run_end    = (run_count_reg == jse_pkg::CountW'(1));
    assign string_end = run_end && run_end_flag_reg;
    assign bad_char   = run_end && run_bad_reg;
    assign out_fire   = out_valid && !out_stall;

    // Take a byte when the run register is empty or its final beat leaves now.
    assign in_stall = !((run_count_reg == '0) || (run_end && !out_stall));
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        run_chars_next    = run_chars_reg;
        run_count_next    = run_count_reg;
        run_end_flag_next = run_end_flag_reg;
        run_bad_next      = run_bad_reg;
        if (in_fire)
        begin
            // load a fresh run
            run_chars_next    = enc_run.chars;
            run_count_next    = enc_run.count;
            run_end_flag_next = enc_run.str_end;
            run_bad_next      = enc_run.bad;
        end
        else if (out_fire)
        begin
            // advance to the next character
            run_chars_next = {8'h00, run_chars_reg[jse_pkg::RunMax-1:1]};
            run_count_next = run_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            run_count_reg <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg <= state_next;
            end
            run_count_reg <= run_count_next;
        end
    end

    // payload of the run: no reset
    always_ff @(posedge clk)
    begin
        run_chars_reg    <= run_chars_next;
        run_end_flag_reg <= run_end_flag_next;
        run_bad_reg      <= run_bad_next;
    end

    `JSE_ASSERT(a_in_only_near_empty, clk, rst_n, in_fire |-> (run_count_reg <= jse_pkg::CountW'(1)), "byte taken while a run is still pending")
    `JSE_ASSERT(a_bad_is_final, clk, rst_n, (out_valid && bad_char) |-> (string_end && run_end && out_char == jse_pkg::CHAR_ERROR), "error beat not closing its string")
    `JSE_ASSERT(a_discard_silent, clk, rst_n, (in_fire && state_reg.disc && !first_byte) |=> (run_count_reg == '0), "discarded byte produced output")
    `JSE_ASSERT(a_drain_step, clk, rst_n, (out_fire && run_count_reg > jse_pkg::CountW'(1)) |=> (run_count_reg == $past(run_count_reg) - 1'b1), "run count did not step down by one")
    `JSE_ASSERT_NEVER(a_need_range, clk, rst_n, state_reg.need == 2'd3, "continuation count out of range")

endmodule
`default_nettype wire

// ----- rtl/jse_encode.sv -----
// Single-pass encoder: one input byte plus state to a run of output characters.
`default_nettype none
module jse_encode (
    input  wire logic [7:0]     in_byte,
    input  wire logic           first_byte,
    input  wire logic           last_byte,
    input  wire logic           force_ucs2,
    input  wire jse_pkg::state_t state_cur,
    output jse_pkg::state_t     state_next,
    output jse_pkg::run_t       run
);

    logic [jse_pkg::RunMax-1:0][7:0] chars;
    logic [jse_pkg::CountW-1:0]      n;
    logic [1:0]                      need_v;
    logic [15:0]                     acc_v;
    logic [15:0]                     acc_shift;
    logic                            disc_v;
    logic                            err;
    logic                            end_f;
    logic                            bad_f;
    logic [7:0]                      esc;

    always_comb
    begin
        chars     = '0;
        n         = '0;
        need_v    = state_cur.need;
        acc_v     = state_cur.acc;
        disc_v    = state_cur.disc;
        err       = 1'b0;
        end_f     = 1'b0;
        bad_f     = 1'b0;
        acc_shift = {acc_v[9:0], in_byte[5:0]};
        esc       = jse_pkg::escape_char(in_byte);

        // a new string drops whatever the previous one left behind
        if (first_byte)
        begin
            need_v   = 2'd0;
            acc_v    = 16'd0;
            disc_v   = 1'b0;
            chars[n] = jse_pkg::CHAR_QUOTE;
            n        = n + 1'b1;
        end

        acc_shift = {acc_v[9:0], in_byte[5:0]};

        if (disc_v)
        begin
            if (last_byte)
            begin
                disc_v = 1'b0;
            end
        end
        else
        begin
            if (need_v != 2'd0)
            begin
                // continuation: any byte counts, take its low six bits
                need_v = need_v - 2'd1;
                if (need_v == 2'd0)
                begin
                    chars[n] = jse_pkg::CHAR_BSLASH;
                    n        = n + 1'b1;
                    chars[n] = jse_pkg::CHAR_U;
                    n        = n + 1'b1;
                    chars[n] = jse_pkg::hex_char(acc_shift[15:12]);
                    n        = n + 1'b1;
                    chars[n] = jse_pkg::hex_char(acc_shift[11:8]);
                    n        = n + 1'b1;
                    chars[n] = jse_pkg::hex_char(acc_shift[7:4]);
                    n        = n + 1'b1;
                    chars[n] = jse_pkg::hex_char(acc_shift[3:0]);
                    n        = n + 1'b1;
                    acc_v    = 16'd0;
                end
                else
                begin
                    acc_v = acc_shift;
                end
            end
            else if (esc != jse_pkg::ESC_NONE)
            begin
                chars[n] = jse_pkg::CHAR_BSLASH;
                n        = n + 1'b1;
                chars[n] = esc;
                n        = n + 1'b1;
            end
            else if (force_ucs2 && in_byte[7])
            begin
                if (in_byte[7:5] == jse_pkg::LEAD_3BYTE)
                begin
                    need_v = 2'd2;
                    acc_v  = {12'd0, in_byte[3:0]};
                end
                else if (in_byte[7:5] == jse_pkg::LEAD_2BYTE)
                begin
                    need_v = 2'd1;
                    acc_v  = {11'd0, in_byte[4:0]};
                end
                else
                begin
                    err = 1'b1;
                end
            end
            else
            begin
                chars[n] = in_byte;
                n        = n + 1'b1;
            end

            // string ends inside a sequence
            if (!err && last_byte && need_v != 2'd0)
            begin
                err = 1'b1;
            end

            if (err)
            begin
                chars[n] = jse_pkg::CHAR_ERROR;
                n        = n + 1'b1;
                end_f    = 1'b1;
                bad_f    = 1'b1;
                need_v   = 2'd0;
                acc_v    = 16'd0;
                disc_v   = !last_byte;
            end
            else if (last_byte)
            begin
                chars[n] = jse_pkg::CHAR_QUOTE;
                n        = n + 1'b1;
                end_f    = 1'b1;
            end
        end
    end

    assign state_next.need = need_v;
    assign state_next.acc  = acc_v;
    assign state_next.disc = disc_v;

    assign run.chars   = chars;
    assign run.count   = n;
    assign run.str_end = end_f;
    assign run.bad     = bad_f;

endmodule
`default_nettype wire
